// ===== rtl/lsenm_pkg.sv =====
// Shared types, constants and the arctangent table of the laser scan edge noise mask.
`timescale 1ns / 1ps

package lsenm_pkg;

   // Window geometry
   localparam int MAX_MASK  = 15;
   localparam int WIN       = 2 * MAX_MASK + 1;
   localparam int HOLD_N    = MAX_MASK + 1;
   localparam int CNT_W     = $clog2(HOLD_N);
   localparam int MW        = $clog2(WIN + MAX_MASK + 1);

   // Field widths
   localparam int RANGE_W   = 24;
   localparam int INC_CFG_W = 16;
   localparam int SPAN_W    = 4;
   localparam int STEP_W    = 32;

   // Fixed point of the angle datapath
   localparam int FRAC_W      = 30;
   localparam int PROD_W      = STEP_W + RANGE_W + 1;
   localparam int XW          = 60;
   localparam int ZW          = 34;
   localparam int CORDIC_N    = 30;
   localparam int ROUND_SHIFT = 17;
   localparam int INC_W       = ZW - ROUND_SHIFT;
   localparam int PI_Q13      = 25736;

   localparam logic signed [ZW-1:0] HALF_PI_Z  = ZW'(64'd1686629713);
   localparam logic signed [ZW-1:0] PI_Z       = ZW'(64'(PI_Q13) << ROUND_SHIFT);
   localparam logic signed [ZW-1:0] ROUND_BIAS = ZW'(64'd65536);

   // atan(2^-i) in Q2.30, rounded to nearest
   localparam logic [31:0] ATAN_Q30 [CORDIC_N] = '{
      32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
      32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
      32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
      32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
      32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
      32'd32,        32'd16,        32'd8,         32'd4,         32'd2
   };

   // Configuration port
   localparam int NUM_REGS = 8;
   localparam int ADDR_W   = $clog2(NUM_REGS * 4);
   localparam int DATA_W   = 32;

   typedef enum logic [2:0] {
      REG_MIN_INCLINE     = 3'd0,
      REG_MAX_INCLINE     = 3'd1,
      REG_MASK_SPAN       = 3'd2,
      REG_MIN_VALID_RANGE = 3'd3,
      REG_MAX_VALID_RANGE = 3'd4,
      REG_SIN_STEP        = 3'd5,
      REG_COS_STEP        = 3'd6,
      REG_ERROR_VALUE     = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic signed [INC_CFG_W-1:0] min_incline;
      logic signed [INC_CFG_W-1:0] max_incline;
      logic [SPAN_W-1:0]           mask_span;
      logic [RANGE_W-1:0]          min_valid_range;
      logic [RANGE_W-1:0]          max_valid_range;
      logic signed [STEP_W-1:0]    sin_step;
      logic signed [STEP_W-1:0]    cos_step;
      logic [RANGE_W-1:0]          error_value;
   } cfg_type;

   // Item leaving the angle pipeline towards the window
   typedef struct packed {
      logic [RANGE_W-1:0] range;
      logic               eos;
      logic               incline_bad;
      logic               range_bad;
   } front_item_type;

   // Result item held in the output queue
   typedef struct packed {
      logic [RANGE_W-1:0] range;
      logic               masked;
      logic               last;
   } out_item_type;

   localparam int FIFO_DEPTH = 4;
   localparam int FPTR_W     = $clog2(FIFO_DEPTH);
   localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

endpackage

// ===== rtl/laser_scan_edge_noise_mask.sv =====
// Top level of the laser scan edge noise mask: window, result queue and ports.
`timescale 1ns / 1ps

// Usage
// The req_ channel takes one range sample per item, with req_tlast on the last
// sample of a scan. The rsp_ channel returns samples in the same order, each
// either passed through or replaced by the error value (rsp_tuser high), with
// rsp_tlast on the last sample of the scan. The user must write registers over the
// csr_ port only while the block is idle; the block itself does not enforce this.
// Throughput is one item per cycle while the receiver keeps up and no scan end is
// flushing. An item passes the 35 register stages of the incline pipeline (an
// accept stage, a product stage, a vector stage, a quadrant set-up stage, 30
// CORDIC iterations and a check stage) before it reaches the window. Results
// leave 15 samples behind their input; the last sample of a scan releases every
// held sample, one per cycle while the result queue has space, and req_tready
// stays low during that flush whenever an item waits at the end of the pipeline.
// Reset empties the pipeline, the window and the result queue; no clearing
// pass is needed. When the receiver stalls, the four-entry result queue fills,
// then the window and the whole incline pipeline stop together and
// req_tready falls; nothing is lost or repeated.
module laser_scan_edge_noise_mask (
   input  logic                         clock,
   input  logic                         reset,
   // Input samples
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [lsenm_pkg::RANGE_W-1:0] req_tdata,  // [23:0] range_mm
   input  logic                         req_tlast,
   // Results
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [lsenm_pkg::RANGE_W-1:0] rsp_tdata,  // [23:0] range_out
   output logic                         rsp_tuser,   // [0] was_masked
   output logic                         rsp_tlast,
   // Configuration
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [lsenm_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [lsenm_pkg::DATA_W-1:0] csr_pwdata,
   output logic [lsenm_pkg::DATA_W-1:0] csr_prdata,
   output logic                         csr_pready
);
   import lsenm_pkg::*;

   cfg_type        cfg;
   logic           advance;
   logic           front_valid;
   front_item_type front_item;

   // Window state
   logic [RANGE_W-1:0] held_ff [HOLD_N];
   logic [RANGE_W-1:0] held_in [HOLD_N];
   logic [RANGE_W-1:0] wnd_held [HOLD_N];
   logic [WIN-1:0]     mask_ff, mask_in, set_bits, wnd_mask;
   logic [CNT_W-1:0]   cnt_ff, cnt_in, left_ff, left_in;
   logic               flush_ff, flush_in;
   logic               take;
   logic [MW-1:0]      pos_w, span_w;

   // Result queue
   out_item_type       fifo_ff [FIFO_DEPTH];
   logic [FPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [FCNT_W-1:0]  fcnt_ff;
   logic               fifo_space, push, pop;
   out_item_type       push_item;

   lsenm_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lsenm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid && advance),
      .in_range  (req_tdata),
      .in_eos    (req_tlast),
      .cfg       (cfg),
      .out_valid (front_valid),
      .out_item  (front_item)
   );

   // The pipeline moves whenever its last stage is empty or handed on.
   assign fifo_space = (fcnt_ff < FCNT_W'(FIFO_DEPTH));
   assign take       = front_valid && !flush_ff && fifo_space;
   assign advance    = !front_valid || take;
   assign req_tready = advance;

   // Mask bits set by the arriving item: incline edge neighbours and an out-of-band range.
   always_comb begin
      pos_w  = MW'(cnt_ff);
      span_w = (MW'(cfg.mask_span) > MW'(MAX_MASK)) ? MW'(MAX_MASK) : MW'(cfg.mask_span);
      set_bits = '0;
      for (int p = 0; p < WIN; p++) begin
         if (front_item.incline_bad
             && ((MW'(p) + span_w) >= pos_w)
             && (MW'(p) < (pos_w + span_w))
             && !(front_item.eos && (MW'(p) > pos_w))) begin
            set_bits[p] = 1'b1;
         end
         if (front_item.range_bad && (MW'(p) == pos_w)) begin
            set_bits[p] = 1'b1;
         end
      end
   end

   // Window update, release of the oldest sample and the scan-end flush.
   always_comb begin
      wnd_held         = held_ff;
      wnd_held[cnt_ff] = front_item.range;
      wnd_mask         = mask_ff | set_bits;

      held_in  = held_ff;
      mask_in  = mask_ff;
      cnt_in   = cnt_ff;
      left_in  = left_ff;
      flush_in = flush_ff;

      push             = 1'b0;
      push_item.range  = mask_ff[0] ? cfg.error_value : held_ff[0];
      push_item.masked = mask_ff[0];
      push_item.last   = 1'b0;

      if (flush_ff) begin
         if (fifo_space) begin
            push           = 1'b1;
            push_item.last = (left_ff == '0);
            for (int i = 0; i < HOLD_N - 1; i++) begin
               held_in[i] = held_ff[i+1];
            end
            mask_in = mask_ff >> 1;
            if (left_ff == '0) begin
               flush_in = 1'b0;
               mask_in  = '0;
               cnt_in   = '0;
            end else begin
               left_in = left_ff - 1'b1;
            end
         end
      end else if (take) begin
         if (front_item.eos) begin
            held_in  = wnd_held;
            mask_in  = wnd_mask;
            flush_in = 1'b1;
            left_in  = cnt_ff;
         end else if (cnt_ff == CNT_W'(MAX_MASK)) begin
            push             = 1'b1;
            push_item.range  = wnd_mask[0] ? cfg.error_value : wnd_held[0];
            push_item.masked = wnd_mask[0];
            for (int i = 0; i < HOLD_N - 1; i++) begin
               held_in[i] = wnd_held[i+1];
            end
            held_in[HOLD_N-1] = wnd_held[HOLD_N-1];
            mask_in = wnd_mask >> 1;
         end else begin
            held_in = wnd_held;
            mask_in = wnd_mask;
            cnt_in  = cnt_ff + 1'b1;
         end
      end
   end

   // Window control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         cnt_ff   <= '0;
         left_ff  <= '0;
         flush_ff <= 1'b0;
      end else begin
         mask_ff  <= mask_in;
         cnt_ff   <= cnt_in;
         left_ff  <= left_in;
         flush_ff <= flush_in;
      end
   end

   // Held ranges carry no reset; an entry is always written before it leaves.
   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

   // Result queue between the window and the receiver.
   assign pop = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fcnt_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         fcnt_ff <= fcnt_ff + FCNT_W'(push) - FCNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign rsp_tvalid = (fcnt_ff != '0);
   assign rsp_tdata  = fifo_ff[rd_ptr_ff].range;
   assign rsp_tuser  = fifo_ff[rd_ptr_ff].masked;
   assign rsp_tlast  = fifo_ff[rd_ptr_ff].last;

endmodule

// ===== rtl/lsenm_regs.sv =====
// Configuration register file with its APB-style access port.
`timescale 1ns / 1ps

module lsenm_regs (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [lsenm_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [lsenm_pkg::DATA_W-1:0] csr_pwdata,
   output logic [lsenm_pkg::DATA_W-1:0] csr_prdata,
   output logic                         csr_pready,
   output lsenm_pkg::cfg_type           cfg
);
   import lsenm_pkg::*;

   cfg_type       cfg_ff;
   reg_index_type index;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign index      = reg_index_type'(csr_paddr[ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   // Register writes in the access cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{
            min_incline:     INC_CFG_W'(0),
            max_incline:     INC_CFG_W'(0),
            mask_span:       SPAN_W'(0),
            min_valid_range: RANGE_W'(0),
            max_valid_range: RANGE_W'(0),
            sin_step:        STEP_W'(0),
            cos_step:        STEP_W'(32'd1073741824),
            error_value:     RANGE_W'(4)
         };
      end else if (wr_en) begin
         case (index)
            REG_MIN_INCLINE:     cfg_ff.min_incline     <= csr_pwdata[INC_CFG_W-1:0];
            REG_MAX_INCLINE:     cfg_ff.max_incline     <= csr_pwdata[INC_CFG_W-1:0];
            REG_MASK_SPAN:       cfg_ff.mask_span       <= csr_pwdata[SPAN_W-1:0];
            REG_MIN_VALID_RANGE: cfg_ff.min_valid_range <= csr_pwdata[RANGE_W-1:0];
            REG_MAX_VALID_RANGE: cfg_ff.max_valid_range <= csr_pwdata[RANGE_W-1:0];
            REG_SIN_STEP:        cfg_ff.sin_step        <= csr_pwdata[STEP_W-1:0];
            REG_COS_STEP:        cfg_ff.cos_step        <= csr_pwdata[STEP_W-1:0];
            REG_ERROR_VALUE:     cfg_ff.error_value     <= csr_pwdata[RANGE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Read-back of the raw register bits.
   always_comb begin
      case (index)
         REG_MIN_INCLINE:     csr_prdata = {{(DATA_W-INC_CFG_W){1'b0}}, cfg_ff.min_incline};
         REG_MAX_INCLINE:     csr_prdata = {{(DATA_W-INC_CFG_W){1'b0}}, cfg_ff.max_incline};
         REG_MASK_SPAN:       csr_prdata = {{(DATA_W-SPAN_W){1'b0}}, cfg_ff.mask_span};
         REG_MIN_VALID_RANGE: csr_prdata = {{(DATA_W-RANGE_W){1'b0}}, cfg_ff.min_valid_range};
         REG_MAX_VALID_RANGE: csr_prdata = {{(DATA_W-RANGE_W){1'b0}}, cfg_ff.max_valid_range};
         REG_SIN_STEP:        csr_prdata = cfg_ff.sin_step;
         REG_COS_STEP:        csr_prdata = cfg_ff.cos_step;
         REG_ERROR_VALUE:     csr_prdata = {{(DATA_W-RANGE_W){1'b0}}, cfg_ff.error_value};
         default:             csr_prdata = '0;
      endcase
   end

endmodule

// ===== rtl/lsenm_front.sv =====
// Incline pipeline: products, vector set-up, one CORDIC iteration a stage, band checks.
`timescale 1ns / 1ps

module lsenm_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic [lsenm_pkg::RANGE_W-1:0] in_range,
   input  logic                          in_eos,
   input  lsenm_pkg::cfg_type            cfg,
   output logic                          out_valid,
   output lsenm_pkg::front_item_type     out_item
);
   import lsenm_pkg::*;

   // Scan history
   logic [RANGE_W-1:0] prev_ff;
   logic               first_ff;

   // Accept stage
   logic               v0_ff, e0_ff, f0_ff;
   logic [RANGE_W-1:0] r0_ff, p0_ff;

   // Product stage
   logic                     v1_ff, e1_ff, f1_ff;
   logic [RANGE_W-1:0]       r1_ff;
   logic signed [PROD_W-1:0] ys1_ff, cp1_ff;
   logic signed [PROD_W-1:0] ys_prod, cp_prod;

   // Vector stage
   logic                 v2_ff, e2_ff, f2_ff;
   logic [RANGE_W-1:0]   r2_ff;
   logic signed [XW-1:0] x2_ff, y2_ff;
   logic signed [XW-1:0] x2_in;

   // CORDIC stages; entry 0 is the set-up stage after the quarter-turn rotation
   logic                 cv_ff [CORDIC_N+1];
   logic                 ce_ff [CORDIC_N+1];
   logic                 ch_ff [CORDIC_N+1];
   logic [RANGE_W-1:0]   cr_ff [CORDIC_N+1];
   logic signed [XW-1:0] cx_ff [CORDIC_N+1];
   logic signed [XW-1:0] cy_ff [CORDIC_N+1];
   logic signed [ZW-1:0] cz_ff [CORDIC_N+1];
   logic signed [XW-1:0] x3_in, y3_in;
   logic signed [ZW-1:0] z3_in;
   logic                 h3_in;

   // Output stage
   logic                 ov_ff;
   front_item_type       item_ff, item_in;
   logic signed [ZW-1:0] z_round;
   logic signed [INC_W-1:0] inc;

   // Products of the previous range with the step sine and cosine.
   assign ys_prod = $signed(cfg.sin_step) * $signed({1'b0, p0_ff});
   assign cp_prod = $signed(cfg.cos_step) * $signed({1'b0, p0_ff});

   // x = cur * 2^30 - cos * prev
   assign x2_in = $signed({{(XW-RANGE_W-FRAC_W){1'b0}}, r1_ff, {FRAC_W{1'b0}}})
                  - XW'(cp1_ff);

   // A zero-y vector and the first sample are frozen; a left half-plane vector turns by a quarter.
   always_comb begin
      x3_in = x2_ff;
      y3_in = y2_ff;
      z3_in = '0;
      h3_in = 1'b0;
      if (f2_ff || (y2_ff == '0)) begin
         h3_in = 1'b1;
         if (!f2_ff && x2_ff[XW-1]) begin
            z3_in = PI_Z;
         end
      end else if (x2_ff[XW-1]) begin
         if (!y2_ff[XW-1]) begin
            x3_in = y2_ff;
            y3_in = -x2_ff;
            z3_in = HALF_PI_Z;
         end else begin
            x3_in = -y2_ff;
            y3_in = x2_ff;
            z3_in = -HALF_PI_Z;
         end
      end
   end

   // Rounding to Q3.13 and the band checks.
   always_comb begin
      z_round = cz_ff[CORDIC_N] + ROUND_BIAS;
      inc     = INC_W'(z_round >>> ROUND_SHIFT);
      item_in.range       = cr_ff[CORDIC_N];
      item_in.eos         = ce_ff[CORDIC_N];
      item_in.incline_bad = (inc < INC_W'($signed(cfg.min_incline)))
                            || (inc > INC_W'($signed(cfg.max_incline)));
      item_in.range_bad   = (cr_ff[CORDIC_N] < cfg.min_valid_range)
                            || (cr_ff[CORDIC_N] > cfg.max_valid_range);
   end

   // Control: valid bits and scan history.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         first_ff <= 1'b1;
         v0_ff    <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         ov_ff    <= 1'b0;
         for (int i = 0; i <= CORDIC_N; i++) begin
            cv_ff[i] <= 1'b0;
         end
      end else begin
         if (in_valid) begin
            prev_ff  <= in_range;
            first_ff <= in_eos;
         end
         if (advance) begin
            v0_ff    <= in_valid;
            v1_ff    <= v0_ff;
            v2_ff    <= v1_ff;
            cv_ff[0] <= v2_ff;
            for (int i = 0; i < CORDIC_N; i++) begin
               cv_ff[i+1] <= cv_ff[i];
            end
            ov_ff <= cv_ff[CORDIC_N];
         end
      end
   end

   // Datapath registers, all moving together.
   always_ff @(posedge clock) begin
      if (advance) begin
         r0_ff  <= in_range;
         e0_ff  <= in_eos;
         p0_ff  <= prev_ff;
         f0_ff  <= first_ff;

         r1_ff  <= r0_ff;
         e1_ff  <= e0_ff;
         f1_ff  <= f0_ff;
         ys1_ff <= ys_prod;
         cp1_ff <= cp_prod;

         r2_ff  <= r1_ff;
         e2_ff  <= e1_ff;
         f2_ff  <= f1_ff;
         x2_ff  <= x2_in;
         y2_ff  <= XW'(ys1_ff);

         cr_ff[0] <= r2_ff;
         ce_ff[0] <= e2_ff;
         ch_ff[0] <= h3_in;
         cx_ff[0] <= x3_in;
         cy_ff[0] <= y3_in;
         cz_ff[0] <= z3_in;

         // One vectoring iteration per stage, driving y towards zero.
         for (int i = 0; i < CORDIC_N; i++) begin
            cr_ff[i+1] <= cr_ff[i];
            ce_ff[i+1] <= ce_ff[i];
            ch_ff[i+1] <= ch_ff[i];
            if (ch_ff[i]) begin
               cx_ff[i+1] <= cx_ff[i];
               cy_ff[i+1] <= cy_ff[i];
               cz_ff[i+1] <= cz_ff[i];
            end else if (!cy_ff[i][XW-1]) begin
               cx_ff[i+1] <= cx_ff[i] + (cy_ff[i] >>> i);
               cy_ff[i+1] <= cy_ff[i] - (cx_ff[i] >>> i);
               cz_ff[i+1] <= cz_ff[i] + $signed(ZW'(ATAN_Q30[i]));
            end else begin
               cx_ff[i+1] <= cx_ff[i] - (cy_ff[i] >>> i);
               cy_ff[i+1] <= cy_ff[i] + (cx_ff[i] >>> i);
               cz_ff[i+1] <= cz_ff[i] - $signed(ZW'(ATAN_Q30[i]));
            end
         end

         item_ff <= item_in;
      end
   end

   assign out_valid = ov_ff;
   assign out_item  = item_ff;

endmodule

// ===== dv/laser_scan_edge_noise_mask_tb.sv =====
// Self-checking testbench of the laser scan edge noise mask, with its own window predictor.
`timescale 1ns / 1ps

module laser_scan_edge_noise_mask_tb;

   import lsenm_pkg::*;

   localparam int     SETTLE_CYCLES  = 64;
   localparam int     WATCHDOG_LIMIT = 2000;
   localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
   localparam int     HALF_TURN_Q13    = 25736;
   localparam longint ONE_Q30          = 64'sd1073741824;

   // One input item waiting to be sent; pause_first holds it back until all results are in
   typedef struct packed {
      logic [RANGE_W-1:0] range;
      logic               last;
      logic               pause_first;
   } scan_sample_type;

   // One result item as the block should deliver it
   typedef struct packed {
      logic [RANGE_W-1:0] range;
      logic               masked;
      logic               last;
   } masked_sample_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_LONG_STALLS
   } ready_pattern_type;

   logic                clock;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [RANGE_W-1:0]  req_tdata   = '0;  // [23:0] range_mm
   logic                req_tlast   = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [RANGE_W-1:0]  rsp_tdata;         // [23:0] range_out
   logic                rsp_tuser;         // [0] was_masked
   logic                rsp_tlast;
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [ADDR_W-1:0]   csr_paddr   = '0;
   logic [DATA_W-1:0]   csr_pwdata  = '0;
   logic [DATA_W-1:0]   csr_prdata;
   logic                csr_pready;

   // Stimulus and expectations
   scan_sample_type     scan_feed [$];
   masked_sample_type   due_samples [$];
   int                  taken_count = 0;
   int                  seen_count  = 0;
   bit                  send_bursty  = 1'b0;
   ready_pattern_type   ready_pattern = READY_ALWAYS;
   int                  burst_left = 0;
   int                  gap_left   = 0;
   int                  stall_left = 0;
   int                  quiet_cycles = 0;
   int                  mismatch_count = 0;
   int                  result_index = 0;

   // Predictor state
   cfg_type             mask_cfg;
   logic [RANGE_W-1:0]  last_range;
   logic                scan_start;
   logic [RANGE_W-1:0]  held_range [MAX_MASK + 1];
   logic                mask_flag [WIN];
   int                  held_count;

   longint arctan_q30 [30] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
      16, 8, 4, 2
   };

   laser_scan_edge_noise_mask i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Clock, 12 ns period
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Vectoring CORDIC giving the incline in Q3.13 radians from Q.30 coordinates.
   function automatic int incline_q13(longint x_in, longint y_in);
      longint x, y, z, t, dx, dy;
      x = x_in;
      y = y_in;
      z = 0;
      if (y == 0) return (x >= 0) ? 0 : HALF_TURN_Q13;
      // Bring a vector in the left half plane into the right one first.
      if (x < 0) begin
         t = x;
         if (y > 0) begin
            x = y;
            y = -t;
            z = QUARTER_TURN_Q30;
         end else begin
            x = -y;
            y = t;
            z = -QUARTER_TURN_Q30;
         end
      end
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            z = z + arctan_q30[i];
         end else begin
            x = x - dx;
            y = y + dy;
            z = z - arctan_q30[i];
         end
      end
      return int'((z + 64'sd65536) >>> 17);
   endfunction

   // Takes one accepted sample into the window and queues the samples it releases.
   task automatic advance_window(logic [RANGE_W-1:0] range_mm, logic end_of_scan);
      int                pos, span, incline, p;
      longint            sin_v, cos_v, prev_v, x, y;
      masked_sample_type res;
      pos = held_count;
      span = int'(mask_cfg.mask_span);
      if (span > MAX_MASK) span = MAX_MASK;
      incline = 0;
      if (!scan_start) begin
         sin_v = longint'($signed(mask_cfg.sin_step));
         cos_v = longint'($signed(mask_cfg.cos_step));
         prev_v = longint'(last_range);
         y = sin_v * prev_v;
         x = longint'(range_mm) * ONE_Q30 - cos_v * prev_v;
         incline = incline_q13(x, y);
      end

      held_range[pos] = range_mm;
      if (range_mm < mask_cfg.min_valid_range || range_mm > mask_cfg.max_valid_range) begin
         mask_flag[pos] = 1'b1;
      end
      // An edge masks its neighbours, clipped to the start and the end of the scan.
      if (incline < int'($signed(mask_cfg.min_incline)) ||
          incline > int'($signed(mask_cfg.max_incline))) begin
         for (p = pos - span; p < pos + span; p++) begin
            if (p >= 0 && p < WIN && !(end_of_scan && p > pos)) mask_flag[p] = 1'b1;
         end
      end
      last_range = range_mm;
      scan_start = 1'b0;

      if (end_of_scan) begin
         // The end of a scan releases every held sample.
         for (p = 0; p <= pos; p++) begin
            res.range = mask_flag[p] ? mask_cfg.error_value : held_range[p];
            res.masked = mask_flag[p];
            res.last = (p == pos);
            due_samples.push_back(res);
         end
         for (p = 0; p < WIN; p++) mask_flag[p] = 1'b0;
         held_count = 0;
         scan_start = 1'b1;
      end else if (pos >= MAX_MASK) begin
         // A full window releases its oldest sample and slides by one.
         res.range = mask_flag[0] ? mask_cfg.error_value : held_range[0];
         res.masked = mask_flag[0];
         res.last = 1'b0;
         due_samples.push_back(res);
         for (p = 0; p < MAX_MASK; p++) held_range[p] = held_range[p + 1];
         for (p = 0; p < WIN - 1; p++) mask_flag[p] = mask_flag[p + 1];
         mask_flag[WIN - 1] = 1'b0;
         held_count = MAX_MASK;
      end else begin
         held_count = pos + 1;
      end
   endtask

   task automatic report_mismatch(string field, longint got, longint want);
      $display("result %0d: %s is 0x%0h, expected 0x%0h", result_index, field, got, want);
      mismatch_count++;
   endtask

   // Monitor: predicts on accepted samples, checks accepted results, guards against hangs.
   always @(posedge clock) begin : observe
      masked_sample_type want;
      if (reset) begin
         last_range = '0;
         scan_start = 1'b1;
         held_count = 0;
         for (int i = 0; i <= MAX_MASK; i++) held_range[i] = '0;
         for (int i = 0; i < WIN; i++) mask_flag[i] = 1'b0;
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (req_tvalid && req_tready) begin
            advance_window(req_tdata, req_tlast);
            taken_count++;
            quiet_cycles = 0;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (due_samples.size() == 0) begin
               report_mismatch("unexpected result, range_out", rsp_tdata, 0);
            end else begin
               want = due_samples.pop_front();
               if (rsp_tdata !== want.range) report_mismatch("range_out", rsp_tdata, want.range);
               if (rsp_tuser !== want.masked) report_mismatch("was_masked", rsp_tuser, want.masked);
               if (rsp_tlast !== want.last) report_mismatch("scan_last", rsp_tlast, want.last);
            end
            result_index++;
            quiet_cycles = 0;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("laser_scan_edge_noise_mask_tb failed");
            $finish;
         end
      end
   end

   // Sample driver: feeds the queued items, in bursts with gaps when asked.
   always @(negedge clock) begin : drive_samples
      logic            offer;
      scan_sample_type next_item;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tlast <= 1'b0;
         seen_count = taken_count;
      end else begin
         offer = req_tvalid && (taken_count == seen_count);
         seen_count = taken_count;
         if (!offer) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (scan_feed.size() != 0 &&
                         !(scan_feed[0].pause_first && due_samples.size() != 0)) begin
               next_item = scan_feed.pop_front();
               offer = 1'b1;
               req_tdata <= next_item.range;
               req_tlast <= next_item.last;
               if (send_bursty) begin
                  if (burst_left == 0) begin
                     burst_left = $urandom_range(1, 24);
                     gap_left = $urandom_range(1, 8);
                  end else begin
                     burst_left--;
                  end
               end
            end
         end
         req_tvalid <= offer;
      end
   end

   // Result receiver: back-pressure following the pattern of the current phase.
   always @(negedge clock) begin : drive_ready
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         case (ready_pattern)
            READY_ALWAYS: begin
               rsp_tready <= 1'b1;
            end
            READY_RANDOM: begin
               rsp_tready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               if (stall_left > 0) stall_left--;
               else if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(4, 30);
               rsp_tready <= (stall_left == 0);
            end
         endcase
      end
   end

   // One register write: setup cycle, then access cycle until pready.
   task automatic write_register(reg_index_type index, logic [DATA_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (index)
         REG_MIN_INCLINE:     mask_cfg.min_incline = value[INC_CFG_W-1:0];
         REG_MAX_INCLINE:     mask_cfg.max_incline = value[INC_CFG_W-1:0];
         REG_MASK_SPAN:       mask_cfg.mask_span = value[SPAN_W-1:0];
         REG_MIN_VALID_RANGE: mask_cfg.min_valid_range = value[RANGE_W-1:0];
         REG_MAX_VALID_RANGE: mask_cfg.max_valid_range = value[RANGE_W-1:0];
         REG_SIN_STEP:        mask_cfg.sin_step = value;
         REG_COS_STEP:        mask_cfg.cos_step = value;
         default:             mask_cfg.error_value = value[RANGE_W-1:0];
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   function automatic cfg_type settings(int min_inc, int max_inc, int span, int min_r,
                                         int max_r, longint sin_v, longint cos_v, int err);
      cfg_type c;
      c.min_incline = INC_CFG_W'(min_inc);
      c.max_incline = INC_CFG_W'(max_inc);
      c.mask_span = SPAN_W'(span);
      c.min_valid_range = RANGE_W'(min_r);
      c.max_valid_range = RANGE_W'(max_r);
      c.sin_step = STEP_W'(sin_v);
      c.cos_step = STEP_W'(cos_v);
      c.error_value = RANGE_W'(err);
      return c;
   endfunction

   function automatic cfg_type random_settings();
      cfg_type               c;
      logic signed [INC_CFG_W-1:0] t;
      c.min_incline = INC_CFG_W'($urandom_range(0, 51472) - 25736);
      c.max_incline = INC_CFG_W'($urandom_range(0, 51472) - 25736);
      // Mostly an ordered band, now and then an empty one.
      if (c.min_incline > c.max_incline && $urandom_range(0, 3) != 0) begin
         t = c.min_incline;
         c.min_incline = c.max_incline;
         c.max_incline = t;
      end
      c.mask_span = SPAN_W'($urandom_range(0, 15));
      c.min_valid_range = RANGE_W'($urandom_range(0, 3000));
      c.max_valid_range = RANGE_W'($urandom_range(10000, 24'hFFFFFF));
      c.sin_step = STEP_W'(longint'($urandom_range(0, 32'h8000_0000)) - ONE_Q30);
      c.cos_step = STEP_W'(longint'($urandom_range(0, 32'h8000_0000)) - ONE_Q30);
      c.error_value = RANGE_W'($urandom);
      return c;
   endfunction

   // Waits until the block is idle, then loads a full register set and the sending and ready style.
   task automatic start_phase(cfg_type c, bit bursty, ready_pattern_type pattern);
      while (scan_feed.size() != 0 || req_tvalid || due_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_register(REG_MIN_INCLINE, {{16{c.min_incline[INC_CFG_W-1]}}, c.min_incline});
      write_register(REG_MAX_INCLINE, {{16{c.max_incline[INC_CFG_W-1]}}, c.max_incline});
      write_register(REG_MASK_SPAN, DATA_W'(c.mask_span));
      write_register(REG_MIN_VALID_RANGE, DATA_W'(c.min_valid_range));
      write_register(REG_MAX_VALID_RANGE, DATA_W'(c.max_valid_range));
      write_register(REG_SIN_STEP, c.sin_step);
      write_register(REG_COS_STEP, c.cos_step);
      write_register(REG_ERROR_VALUE, DATA_W'(c.error_value));
      send_bursty = bursty;
      ready_pattern = pattern;
   endtask

   task automatic queue_sample(logic [RANGE_W-1:0] range, logic last, logic pause_first);
      scan_sample_type s;
      s.range = range;
      s.last = last;
      s.pause_first = pause_first;
      scan_feed.push_back(s);
   endtask

   // A scan that mostly drifts slowly, with jumps, extremes and arbitrary readings mixed in.
   task automatic queue_scan(int length, logic [RANGE_W-1:0] centre);
      logic [RANGE_W-1:0] r;
      int                 hold_at, pick;
      r = centre;
      hold_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, length - 1) : -1;
      for (int i = 0; i < length; i++) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) r = RANGE_W'($urandom);
         else if (pick == 1) r = ($urandom_range(0, 1) != 0) ? '1 : '0;
         else if (pick < 5) r = centre + RANGE_W'($urandom_range(0, 8000));
         else r = r + RANGE_W'($urandom_range(0, 40)) - RANGE_W'(20);
         queue_sample(r, i == length - 1, i == hold_at);
      end
   endtask

   task automatic queue_random_scans(int total, logic [RANGE_W-1:0] centre);
      int queued, length;
      queued = 0;
      while (queued < total) begin
         length = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 15);
         queue_scan(length, centre);
         queued += length;
      end
   endtask

   // Stimulus: directed scans first, then random phases under varied settings.
   initial begin : stimulus
      cfg_type fine_step, coarse_step;
      fine_step = settings(1430, 24306, 4, 100, 60000, 4685069, 1073731602, 0);
      coarse_step = settings(1430, 24306, 1, 500, 20000, 18739337, 1073578293, 4);

      // The predictor starts from the register values after reset.
      mask_cfg = '0;
      mask_cfg.cos_step = 32'sd1073741824;
      mask_cfg.error_value = 24'd4;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Realistic settings: a lone sample, then a long scan with a far jump,
      // a drop back, a pause mid-scan and an edge on the final sample.
      start_phase(fine_step, 1'b0, READY_ALWAYS);
      queue_sample(24'd0, 1'b1, 1'b0);
      queue_sample(24'hFFFFFF, 1'b0, 1'b0);
      queue_sample(24'd5000, 1'b0, 1'b0);
      queue_sample(24'd5010, 1'b0, 1'b0);
      queue_sample(24'd5020, 1'b0, 1'b0);
      queue_sample(24'd5030, 1'b0, 1'b0);
      queue_sample(24'd9000, 1'b0, 1'b0);
      queue_sample(24'd9010, 1'b0, 1'b0);
      queue_sample(24'd9020, 1'b0, 1'b0);
      queue_sample(24'd9030, 1'b0, 1'b1);
      queue_sample(24'd3000, 1'b0, 1'b0);
      queue_sample(24'd3010, 1'b0, 1'b0);
      queue_sample(24'd3020, 1'b0, 1'b0);
      queue_sample(24'd3030, 1'b0, 1'b0);
      queue_sample(24'd3040, 1'b0, 1'b0);
      queue_sample(24'd3050, 1'b0, 1'b0);
      queue_sample(24'd3060, 1'b0, 1'b0);
      queue_sample(24'd3070, 1'b0, 1'b0);
      queue_sample(24'd20000, 1'b1, 1'b0);

      // Empty incline band and no sine: zero vectors pointing both ways.
      start_phase(settings(25736, -25736, 2, 0, 24'hFFFFFF, 0, ONE_Q30, 24'hFFFFFF),
                  1'b0, READY_RANDOM);
      queue_sample(24'd3000, 1'b0, 1'b0);
      queue_sample(24'd2000, 1'b0, 1'b0);
      queue_sample(24'd0, 1'b0, 1'b0);
      queue_sample(24'd0, 1'b0, 1'b0);
      queue_sample(24'd700, 1'b1, 1'b0);

      // Random phases
      start_phase(settings(-25736, 25736, 15, 0, 24'hFFFFFF, ONE_Q30, -ONE_Q30, 24'hFFFFFF),
                  1'b0, READY_ALWAYS);
      queue_random_scans(12, RANGE_W'($urandom_range(0, 20000)));

      start_phase(coarse_step, 1'b1, READY_RANDOM);
      queue_random_scans(12, 24'd4000);

      start_phase(random_settings(), 1'b1, READY_LONG_STALLS);
      queue_random_scans(12, RANGE_W'($urandom_range(0, 20000)));

      start_phase(settings(25736, 25736, 0, 24'hFFFFFF, 24'hFFFFFF, -ONE_Q30, 0, 0),
                  1'b0, READY_LONG_STALLS);
      queue_random_scans(12, RANGE_W'($urandom_range(0, 20000)));

      start_phase(random_settings(), 1'b1, READY_RANDOM);
      queue_random_scans(12, RANGE_W'($urandom_range(0, 20000)));

      fine_step.mask_span = 4'd15;
      start_phase(fine_step, 1'b1, READY_ALWAYS);
      queue_random_scans(12, 24'd6000);

      // Let every result drain, then allow for stragglers.
      while (scan_feed.size() != 0 || req_tvalid || due_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("laser_scan_edge_noise_mask_tb passed");
      end else begin
         $display("laser_scan_edge_noise_mask_tb failed");
      end
      $finish;
   end

endmodule
